// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and helpers for the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

	typedef enum logic [3:0] {
		PH_START = 4'd0,
		PH_ZERO  = 4'd1,
		PH_HEXP  = 4'd2,
		PH_HEX   = 4'd3,
		PH_OCT   = 4'd4,
		PH_BINP  = 4'd5,
		PH_BIN   = 4'd6,
		PH_DEC   = 4'd7,
		PH_SUF   = 4'd8,
		PH_ERR   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		BASE_2  = 2'd0,
		BASE_8  = 2'd1,
		BASE_10 = 2'd2,
		BASE_16 = 2'd3
	} base_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic        sat;
		logic        suf;
	} parse_state_t;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_1  = 8'h31;
	localparam logic [7:0] CH_7  = 8'h37;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UB = 8'h42;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_UU = 8'h55;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LB = 8'h62;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_LX = 8'h78;

	localparam logic [4:0] DIGIT_NONE = 5'd16;

	localparam parse_state_t STATE_RESET = '{phase: PH_START, acc: 64'd0,
		sat: 1'b0, suf: 1'b0};

	// Hex digit value, DIGIT_NONE if not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= CH_0 && c <= CH_9) begin
				t = c - CH_0;
			end else if (c >= CH_LA && c <= CH_LF) begin
				t = c - CH_LA + 8'd10;
			end else if (c >= CH_UA && c <= CH_UF) begin
				t = c - CH_UA + 8'd10;
			end else begin
				t = {3'd0, DIGIT_NONE};
			end
			return t[4:0];
		end
	endfunction

endpackage

// ----- design/ilp_step.sv -----
// ----------------------------------------------------------------------------
// ilp_step
// Next-state logic for one character: phase transition and base-N
// multiply-add of the accumulator with saturation.
// ----------------------------------------------------------------------------
module ilp_step
	import ilp_pkg::*;
(
	input  parse_state_t cur,
	input  logic [7:0]   char_code,
	output parse_state_t nxt,
	output logic         form_ok
);

	logic [4:0]  h;
	logic        is_hex;
	logic        is_dec;
	logic        is_oct;
	logic        is_bin;
	logic        do_push;
	base_t       base;
	logic [67:0] acc_x;
	logic [67:0] prod;
	logic [67:0] sum;

	assign h      = hex_val(char_code);
	assign is_hex = (h != DIGIT_NONE);
	assign is_dec = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_oct = (char_code >= CH_0) && (char_code <= CH_7);
	assign is_bin = (char_code == CH_0) || (char_code == CH_1);
	assign acc_x  = {4'd0, cur.acc};

	always_comb begin
		unique case (base)
			BASE_2:  prod = acc_x << 1;
			BASE_8:  prod = acc_x << 3;
			BASE_10: prod = (acc_x << 3) + (acc_x << 1);
			BASE_16: prod = acc_x << 4;
			default: prod = acc_x;
		endcase
	end

	assign sum = prod + {64'd0, h[3:0]};

	always_comb begin
		nxt     = cur;
		do_push = 1'b0;
		base    = BASE_10;
		unique case (cur.phase)
			PH_START: begin
				if (char_code == CH_0) begin
					nxt.phase = PH_ZERO;
				end else if (is_dec) begin
					nxt.phase = PH_DEC;
					do_push   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_ZERO: begin
				if (char_code == CH_LX || char_code == CH_UX) begin
					nxt.phase = PH_HEXP;
				end else if (char_code == CH_LB || char_code == CH_UB) begin
					nxt.phase = PH_BINP;
				end else if (is_oct) begin
					nxt.phase = PH_OCT;
					base      = BASE_8;
					do_push   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_HEXP, PH_HEX: begin
				if (is_hex) begin
					nxt.phase = PH_HEX;
					base      = BASE_16;
					do_push   = 1'b1;
				end else if (char_code == CH_UU && cur.phase == PH_HEX) begin
					nxt.phase = PH_SUF;
					nxt.suf   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_OCT: begin
				if (is_oct) begin
					base    = BASE_8;
					do_push = 1'b1;
				end else if (char_code == CH_UU) begin
					nxt.phase = PH_SUF;
					nxt.suf   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_BINP, PH_BIN: begin
				if (is_bin) begin
					nxt.phase = PH_BIN;
					base      = BASE_2;
					do_push   = 1'b1;
				end else if (char_code == CH_UU && cur.phase == PH_BIN) begin
					nxt.phase = PH_SUF;
					nxt.suf   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_DEC: begin
				if (is_dec) begin
					do_push = 1'b1;
				end else if (char_code == CH_UU) begin
					nxt.phase = PH_SUF;
					nxt.suf   = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			default: begin
				nxt.phase = PH_ERR;
			end
		endcase

		if (do_push) begin
			if (cur.sat || (|sum[67:64])) begin
				nxt.sat = 1'b1;
				nxt.acc = '1;
			end else begin
				nxt.acc = sum[63:0];
			end
		end
	end

	assign form_ok = (nxt.phase == PH_HEX) || (nxt.phase == PH_OCT) ||
		(nxt.phase == PH_BIN) || (nxt.phase == PH_DEC) || (nxt.phase == PH_SUF);

endmodule

// ----- design/integer_literal_parser.sv -----
// Parses C-style integer literals (hex, octal, binary, decimal, optional U
// suffix) one character per item, one item per clock cycle sustained. A
// character is registered on acceptance and folded into the literal state
// from the input register; the result of a literal is loaded into the output
// register by that same fold and offered from there. A result that is not
// taken holds only the next final character; other characters keep flowing.
// The per-cycle limit is the accumulator loop: one constant-base multiply-add
// with overflow check per character.
// ----------------------------------------------------------------------------
// integer_literal_parser
// Top level: input register, literal state, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_literal_parser
	import ilp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        literal_valid,
	output logic [63:0] literal_value,
	output logic        unsigned_suffix
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t nxt;
	logic         form_ok;
	logic         out_free;
	logic         advance;
	logic         res_valid_s2;
	logic         lit_valid_s2;
	logic [63:0]  lit_value_s2;
	logic         lit_suf_s2;

	ilp_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.nxt       (nxt),
		.form_ok   (form_ok)
	);

	assign out_free   = !res_valid_s2 || result_ready;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= last_s1 ? STATE_RESET : nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			lit_valid_s2 <= form_ok;
			lit_value_s2 <= form_ok ? nxt.acc : 64'd0;
			lit_suf_s2   <= form_ok && nxt.suf;
		end
	end

	assign result_valid    = res_valid_s2;
	assign literal_valid   = lit_valid_s2;
	assign literal_value   = lit_value_s2;
	assign unsigned_suffix = lit_suf_s2;

	`ASSERT_IMPL(a_sat_ones, state_q.sat, &state_q.acc, "saturated but accumulator not all ones")
	`ASSERT_IMPL(a_suf_phase, state_q.suf,
		state_q.phase == PH_SUF || state_q.phase == PH_ERR, "suffix flag in wrong phase")
	`ASSERT_IMPL(a_bad_zero, result_valid && !literal_valid,
		literal_value == 64'd0 && !unsigned_suffix, "rejected literal carries data")
	`ASSERT_IMPL(a_res_src, $rose(result_valid), $past(advance && last_s1),
		"result without a final character")

endmodule
